@@ design/dexph_pkg.sv @@
`default_nettype none

package dexph_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = 2;
   localparam int ORB_W     = 7;
   localparam int CNT_W     = 8;
   localparam int KIND_W    = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;

   localparam logic [KIND_W-1:0] KIND_ANN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CRE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic                 found;
      logic                 from_ann;
      logic [WORD_BITS-1:0] low;
      logic [BIT_W-1:0]     bit_idx;
      logic                 more;
   } pick_type;

endpackage

`default_nettype wire

@@ design/dexph_pick.sv @@
`default_nettype none

module dexph_pick (
   input  wire logic [dexph_pkg::WORD_BITS-1:0] ann,
   input  wire logic [dexph_pkg::WORD_BITS-1:0] cre,
   output dexph_pkg::pick_type                  pick
);

   logic [dexph_pkg::WORD_BITS-1:0] src;
   logic [dexph_pkg::WORD_BITS-1:0] low;
   logic [dexph_pkg::WORD_BITS-1:0] rest;
   logic [dexph_pkg::BIT_W-1:0]     enc;

   always_comb begin
      src  = (ann != '0) ? ann : cre;
      low  = src & (~src + {{(dexph_pkg::WORD_BITS-1){1'b0}}, 1'b1});
      rest = src & ~low;
      enc  = '0;
      for (int i = 0; i < dexph_pkg::WORD_BITS; i++) begin
         if (low[i]) begin
            enc = enc | dexph_pkg::BIT_W'(i);
         end
      end
      pick.found    = (src != '0);
      pick.from_ann = (ann != '0);
      pick.low      = low;
      pick.bit_idx  = enc;
      // anything left in this word after the chosen bit
      pick.more     = (ann != '0) ? ((rest != '0) || (cre != '0)) : (rest != '0);
   end

endmodule

`default_nettype wire

@@ design/determinant_excitation_phase_top.sv @@
`default_nettype none

// compares a ket and a bra occupation bitstring word by word
// req channel: one transaction per word, tdata = ket_word[31:0], bra_word[63:32],
//   word_index[65:64], zero pad; tlast = last_word; word_index 0 starts a new pair
// rsp channel: tdata = orbital[6:0], phase[7], ann_count[15:8], cre_count[23:16];
//   tuser = kind (annihilation, creation, summary); tlast marks the summary
// per word: annihilation indices ascending, then creation indices ascending,
//   then the summary after the last word
// a taken word goes to the work register; its results are registered in the output register
// throughput: one result per cycle from the output register while rsp_tready is high;
//   results come one at a time from the single lowest-bit picker in the work register
// a word is taken in the same cycle its predecessor hands over its final result
// reset clears busy, last, the ann/cre bits, output valid and all phase and count state
// when rsp_tready is low the result holds, the word in work waits, and req_tready
//   drops once the work register cannot drain

module determinant_excitation_phase_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [dexph_pkg::REQ_DATA_W-1:0]   req_tdata,   // ket_word, bra_word, word_index, pad
   input  wire logic                               req_tlast,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [dexph_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // orbital, phase, ann_count, cre_count
   output      logic [1:0]                         rsp_tuser,   // kind
   output      logic                               rsp_tlast
);

   localparam int WB = dexph_pkg::WORD_BITS;

   logic [WB-1:0] ket;
   logic [WB-1:0] bra;
   logic [dexph_pkg::IDX_W-1:0] idx;
   logic [WB-1:0] common;
   logic [WB-1:0] scan;
   logic          cp_base;

   logic                         busy_ff, busy_in;
   logic [WB-1:0]                ann_ff, ann_in;
   logic [WB-1:0]                cre_ff, cre_in;
   logic [WB-1:0]                pp_ff, pp_in;
   logic [dexph_pkg::IDX_W-1:0]  base_ff, base_in;
   logic                         last_ff, last_in;
   logic                         cp_ff, cp_in;
   logic                         phase_ff, phase_in;
   logic [dexph_pkg::CNT_W-1:0]  ann_cnt_ff, ann_cnt_in;
   logic [dexph_pkg::CNT_W-1:0]  cre_cnt_ff, cre_cnt_in;

   logic                         out_valid_ff, out_valid_in;
   logic [dexph_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [dexph_pkg::ORB_W-1:0]  out_orb_ff, out_orb_in;
   logic                         out_phase_ff, out_phase_in;
   logic [dexph_pkg::CNT_W-1:0]  out_ann_ff, out_ann_in;
   logic [dexph_pkg::CNT_W-1:0]  out_cre_ff, out_cre_in;
   logic                         out_last_ff, out_last_in;

   dexph_pkg::pick_type pick;

   logic has_work;
   logic out_free;
   logic emit;
   logic finish;
   logic take;
   logic emit_sum;

   dexph_pick u_pick (
      .ann  (ann_ff),
      .cre  (cre_ff),
      .pick (pick)
   );

   always_comb begin
      ket    = req_tdata[WB-1:0];
      bra    = req_tdata[2*WB-1:WB];
      idx    = req_tdata[2*WB+dexph_pkg::IDX_W-1:2*WB];
      common = ket & bra;
      // inclusive prefix parity of the common bits
      scan   = common;
      for (int lvl = 0; lvl < dexph_pkg::BIT_W; lvl++) begin
         scan = scan ^ (scan << (1 << lvl));
      end
      cp_base = (idx == '0) ? 1'b0 : cp_ff;
   end

   always_comb begin
      has_work = busy_ff && (pick.found || last_ff);
      out_free = !out_valid_ff || rsp_tready;
      emit     = has_work && out_free;
      emit_sum = emit && !pick.found;
      finish   = busy_ff && (!has_work || (emit && (!pick.found || (!pick.more && !last_ff))));
      req_tready = !busy_ff || finish;
      take     = req_tvalid && req_tready;

      busy_in  = busy_ff;
      ann_in   = ann_ff;
      cre_in   = cre_ff;
      pp_in    = pp_ff;
      base_in  = base_ff;
      last_in  = last_ff;
      cp_in    = cp_ff;
      phase_in = phase_ff;
      ann_cnt_in = ann_cnt_ff;
      cre_cnt_in = cre_cnt_ff;

      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_orb_in   = out_orb_ff;
      out_phase_in = out_phase_ff;
      out_ann_in   = out_ann_ff;
      out_cre_in   = out_cre_ff;
      out_last_in  = out_last_ff;

      if (out_free) begin
         out_valid_in = emit;
      end

      if (emit) begin
         if (pick.found) begin
            out_kind_in  = pick.from_ann ? dexph_pkg::KIND_ANN : dexph_pkg::KIND_CRE;
            out_orb_in   = {base_ff, pick.bit_idx};
            out_phase_in = 1'b0;
            out_ann_in   = '0;
            out_cre_in   = '0;
            out_last_in  = 1'b0;
            phase_in     = phase_ff ^ ((pp_ff & pick.low) != '0);
            if (pick.from_ann) begin
               ann_in = ann_ff & ~pick.low;
               if (ann_cnt_ff != dexph_pkg::CNT_MAX) begin
                  ann_cnt_in = ann_cnt_ff + 1'b1;
               end
            end else begin
               cre_in = cre_ff & ~pick.low;
               if (cre_cnt_ff != dexph_pkg::CNT_MAX) begin
                  cre_cnt_in = cre_cnt_ff + 1'b1;
               end
            end
         end else begin
            out_kind_in  = dexph_pkg::KIND_SUM;
            out_orb_in   = '0;
            out_phase_in = phase_ff;
            out_ann_in   = ann_cnt_ff;
            out_cre_in   = cre_cnt_ff;
            out_last_in  = 1'b1;
            last_in      = 1'b0;
         end
      end

      if (emit_sum) begin
         phase_in   = 1'b0;
         ann_cnt_in = '0;
         cre_cnt_in = '0;
      end

      if (finish) begin
         busy_in = 1'b0;
      end

      if (take) begin
         busy_in = 1'b1;
         ann_in  = ket & ~bra;
         cre_in  = bra & ~ket;
         // exclusive prefix parity folded with the parity of earlier words
         pp_in   = {scan[WB-2:0], 1'b0} ^ {WB{cp_base}};
         base_in = idx;
         last_in = req_tlast;
         cp_in   = req_tlast ? 1'b0 : (cp_base ^ scan[WB-1]);
         if (idx == '0) begin
            phase_in   = 1'b0;
            ann_cnt_in = '0;
            cre_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         last_ff      <= 1'b0;
         cp_ff        <= 1'b0;
         phase_ff     <= 1'b0;
         ann_cnt_ff   <= '0;
         cre_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
         ann_ff       <= '0;
         cre_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         last_ff      <= last_in;
         cp_ff        <= cp_in;
         phase_ff     <= phase_in;
         ann_cnt_ff   <= ann_cnt_in;
         cre_cnt_ff   <= cre_cnt_in;
         out_valid_ff <= out_valid_in;
         ann_ff       <= ann_in;
         cre_ff       <= cre_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff        <= pp_in;
      base_ff      <= base_in;
      out_kind_ff  <= out_kind_in;
      out_orb_ff   <= out_orb_in;
      out_phase_ff <= out_phase_in;
      out_ann_ff   <= out_ann_in;
      out_cre_ff   <= out_cre_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_cre_ff, out_ann_ff, out_phase_ff, out_orb_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

@@ design/dexph_check.sv @@
`default_nettype none

module dexph_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [71:0] req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic unused_ok;
   assign unused_ok = req_tvalid ^ req_tlast ^ (^req_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == dexph_pkg::KIND_SUM) == rsp_tlast))
      else $error("summary and tlast disagree");

   a_index_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[23:7] == '0)
      else $error("phase or counts on an index transaction");

   a_sum_no_orb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[6:0] == '0)
      else $error("orbital on a summary transaction");

endmodule

bind determinant_excitation_phase_top dexph_check u_dexph_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ test/excitation_checker.sv @@
`timescale 1ns / 1ps

module excitation_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,   // ket_word, bra_word, word_index, pad
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // orbital, phase, ann_count, cre_count
   input  wire logic [1:0]  rsp_tuser,   // kind
   input  wire logic        rsp_tlast,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      logic [dexph_pkg::KIND_W-1:0] kind;
      logic [dexph_pkg::ORB_W-1:0]  orbital;
      logic                         phase;
      logic [dexph_pkg::CNT_W-1:0]  ann_count;
      logic [dexph_pkg::CNT_W-1:0]  cre_count;
      logic                         last;
   } excitation_type;

   excitation_type              excitation_q[$];
   logic                        common_par;
   logic                        phase_par;
   logic [dexph_pkg::CNT_W-1:0] ann_tot;
   logic [dexph_pkg::CNT_W-1:0] cre_tot;

   task automatic clear_pair();
      common_par = 1'b0;
      phase_par  = 1'b0;
      ann_tot    = '0;
      cre_tot    = '0;
   endtask

   function automatic logic [dexph_pkg::CNT_W-1:0] sat_bump(
      input logic [dexph_pkg::CNT_W-1:0] c);
      return (c == dexph_pkg::CNT_MAX) ? c : c + 1'b1;
   endfunction

   // walks the differing bits upward, each one flips the phase by the common bits below it
   task automatic scan_diff(input logic [dexph_pkg::WORD_BITS-1:0] diff,
                            input logic [dexph_pkg::WORD_BITS-1:0] common,
                            input int base, input logic [dexph_pkg::KIND_W-1:0] kind);
      logic           below;
      excitation_type e;
      below = 1'b0;
      for (int b = 0; b < dexph_pkg::WORD_BITS; b++) begin
         if (diff[b]) begin
            phase_par ^= common_par ^ below;
            if (kind == dexph_pkg::KIND_ANN) begin
               ann_tot = sat_bump(ann_tot);
            end else begin
               cre_tot = sat_bump(cre_tot);
            end
            e         = '0;
            e.kind    = kind;
            e.orbital = dexph_pkg::ORB_W'(base + b);
            excitation_q.push_back(e);
         end
         below ^= common[b];
      end
   endtask

   task automatic predict_word(input logic [dexph_pkg::WORD_BITS-1:0] ket,
                               input logic [dexph_pkg::WORD_BITS-1:0] bra,
                               input logic [dexph_pkg::IDX_W-1:0] idx, input logic last_word);
      logic [dexph_pkg::WORD_BITS-1:0] common;
      excitation_type                  e;
      if (idx == '0) begin
         clear_pair();
      end
      common = ket & bra;
      scan_diff(ket & ~bra, common, int'(idx) * dexph_pkg::WORD_BITS, dexph_pkg::KIND_ANN);
      scan_diff(bra & ~ket, common, int'(idx) * dexph_pkg::WORD_BITS, dexph_pkg::KIND_CRE);
      common_par ^= ^common;
      if (last_word) begin
         e           = '0;
         e.kind      = dexph_pkg::KIND_SUM;
         e.phase     = phase_par;
         e.ann_count = ann_tot;
         e.cre_count = cre_tot;
         e.last      = 1'b1;
         excitation_q.push_back(e);
         clear_pair();
      end
   endtask

   task automatic report(input string field, input int unsigned want, input int unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      excitation_type got;
      excitation_type want;
      if (reset) begin
         excitation_q.delete();
         clear_pair();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind      = rsp_tuser;
            got.orbital   = rsp_tdata[6:0];
            got.phase     = rsp_tdata[7];
            got.ann_count = rsp_tdata[15:8];
            got.cre_count = rsp_tdata[23:16];
            got.last      = rsp_tlast;
            if (excitation_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transaction, expected none, actual kind %0d orbital %0d",
                        $time, got.kind, got.orbital);
            end else begin
               want = excitation_q.pop_front();
               if (got.kind !== want.kind) report("kind", want.kind, got.kind);
               if (got.orbital !== want.orbital) report("orbital", want.orbital, got.orbital);
               if (got.phase !== want.phase) report("phase", want.phase, got.phase);
               if (got.ann_count !== want.ann_count) begin
                  report("ann_count", want.ann_count, got.ann_count);
               end
               if (got.cre_count !== want.cre_count) begin
                  report("cre_count", want.cre_count, got.cre_count);
               end
               if (got.last !== want.last) report("last", want.last, got.last);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tdata[31:0], req_tdata[63:32], req_tdata[65:64], req_tlast);
         end
      end
      outstanding <= excitation_q.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_WORDS = 155;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // ket_word, bra_word, word_index, pad
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // orbital, phase, ann_count, cre_count
   logic [1:0]  rsp_tuser;        // kind
   logic        rsp_tlast;

   int mismatches;
   int outstanding;
   int cycles = 0;
   int ready_hold = 0;
   int words_sent = 0;
   bit quiet = 1'b0;

   always #5 clock = ~clock;

   determinant_excitation_phase_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   excitation_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [31:0] random_occupancy();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic send_word(input logic [31:0] ket, input logic [31:0] bra,
                            input logic [1:0] idx, input logic last_word);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idx, bra, ket};
      req_tlast  <= last_word;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int          words;
      int          style;
      int          base_count;
      logic [31:0] ket;
      logic [31:0] flip;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty pair, summary only
      send_word('0, '0, 2'd0, 1'b1);
      // full annihilation, full creation, all common, top orbital
      send_word('1, '0, 2'd0, 1'b0);
      send_word('0, '1, 2'd1, 1'b0);
      send_word('1, '1, 2'd2, 1'b0);
      send_word(32'h8000_0001, 32'h0000_0001, 2'd3, 1'b1);
      // word zero in mid pair restarts it
      send_word(32'h0000_00f0, 32'h0000_000f, 2'd0, 1'b0);
      send_word(32'h0000_0003, 32'h0000_0006, 2'd0, 1'b1);
      // out of order words with no word zero, both counts saturate
      for (int i = 0; i < 18; i++) begin
         send_word(32'h5555_5555, 32'haaaa_aaab, 2'(i % 3 + 1), i == 17);
      end

      base_count = words_sent;
      while (words_sent < base_count + RANDOM_WORDS) begin
         quiet = ($urandom_range(0, 5) == 0);
         style = $urandom_range(0, 9);
         words = $urandom_range(1, 4);
         if (style < 8) begin
            for (int w = 0; w < words; w++) begin
               ket = random_occupancy();
               case ($urandom_range(0, 9))
                  0: flip = '0;
                  1, 2: flip = $urandom;
                  default: flip = (32'd1 << $urandom_range(0, 31)) |
                                  (32'd1 << $urandom_range(0, 31));
               endcase
               send_word(ket, ket ^ flip, 2'(w), w == words - 1);
            end
         end else begin
            // broken sequences: any index, last word at random
            for (int w = 0; w < words; w++) begin
               send_word(random_occupancy(), random_occupancy(), 2'($urandom_range(0, 3)),
                         $urandom_range(0, 3) == 0);
            end
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
